### design/htc_pkg.sv
// Shared types, constants and the ADC conversion for the heater controller.
package htc_pkg;

  localparam int KIND_W     = 2;
  localparam int ADC_W      = 12;
  localparam int TEMP_W     = 10;
  localparam int MODE_W     = 3;
  localparam int POWER_W    = 7;
  localparam int ERR_W      = 11;
  localparam int GAIN_W     = 12;
  localparam int INTEG_W    = 15;
  localparam int TICK_W     = 32;
  localparam int TIMEOUT_W  = 16;
  localparam int TUNE_CNT_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WAKE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TUNE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HEAT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLEEP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ERROR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TUNE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TEMP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_TEMP    = 2'd2;

  localparam logic [TEMP_W-1:0]    SLEEP_TEMP_RESET    = 10'd150;
  localparam logic [TIMEOUT_W-1:0] SLEEP_TIMEOUT_RESET = 16'd600;
  localparam logic [TEMP_W-1:0]    ERROR_TEMP_RESET    = 10'd900;
  localparam logic [TEMP_W-1:0]    TEMP_RESET          = 10'd25;

  localparam int POWER_MAX = 100;
  localparam int INTEG_MAX = 25600;
  localparam logic signed [ERR_W-1:0] ERR_WINDOW = 11'sd30;
  localparam logic [POWER_W-1:0] TUNE_POWER = 7'd80;
  localparam logic [TUNE_CNT_W-1:0] TUNE_ROUNDS  = 3'd4;
  localparam logic [TUNE_CNT_W-1:0] TUNE_CNT_MAX = 3'd7;

  localparam logic [ADC_W-1:0] ADC_FULL = 12'd4095;
  localparam logic [ADC_W-1:0] ADC_BP1  = 12'd1000;
  localparam logic [ADC_W-1:0] ADC_BP2  = 12'd2000;
  localparam logic [ADC_W-1:0] ADC_BP3  = 12'd3100;
  localparam logic [TEMP_W-1:0] TEMP_FULL = 10'd999;

  // reciprocals of 5, 10 and 11 scaled by 2^16
  localparam int RECIP_SHIFT = 16;
  localparam logic [13:0] RECIP_5  = 14'd13108;
  localparam logic [13:0] RECIP_10 = 14'd6554;
  localparam logic [13:0] RECIP_11 = 14'd5958;

  typedef struct packed {
    logic [GAIN_W-1:0] p;
    logic [GAIN_W-1:0] i;
    logic [GAIN_W-1:0] d;
  } gains_t;

  localparam gains_t GAINS_RESET = '{p: 12'd307,  i: 12'd38,   d: 12'd102};
  localparam gains_t GAINS_TUNED = '{p: 12'd2841, i: 12'd1420, d: 12'd1420};

  typedef struct packed {
    logic [POWER_W-1:0]      pct;
    logic [INTEG_W-1:0]      integ;
    logic signed [ERR_W-1:0] err;
  } pid_out_t;

  function automatic logic [TEMP_W-1:0] adc_to_degrees(input logic [ADC_W-1:0] a);
    logic [10:0]       x;
    logic [13:0]       m;
    logic [TEMP_W-1:0] base;
    logic [24:0]       prod;
    logic [TEMP_W-1:0] deg;
    priority if (a <= ADC_BP1) begin
      x    = a[10:0];
      m    = RECIP_5;
      base = 10'd25;
    end else if (a <= ADC_BP2) begin
      x    = 11'(a - ADC_BP1);
      m    = RECIP_10;
      base = 10'd225;
    end else if (a <= ADC_BP3) begin
      x    = 11'(a - ADC_BP2);
      m    = RECIP_11;
      base = 10'd325;
    end else begin
      x    = 11'(a - ADC_BP3);
      m    = RECIP_11;
      base = 10'd425;
    end
    prod = 25'(x) * 25'(m);
    deg  = base + {1'b0, prod[24:RECIP_SHIFT]};
    if (a == ADC_FULL) begin
      deg = TEMP_FULL;
    end
    return deg;
  endfunction

endpackage

### design/htc_ifs.sv
// Handshake channels of the heater controller: items, results, register writes.
interface htc_item_if import htc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADC_W-1:0]  adc_sample;
  logic              master_on;
  logic [TEMP_W-1:0] setpoint;

  modport source (output valid, kind, adc_sample, master_on, setpoint, input ready);
  modport sink   (input valid, kind, adc_sample, master_on, setpoint, output ready);
endinterface

interface htc_result_if import htc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               heater_on;
  logic [MODE_W-1:0]  mode;
  logic [TEMP_W-1:0]  temperature;
  logic [POWER_W-1:0] power;

  modport source (output valid, heater_on, mode, temperature, power, input ready);
  modport sink   (input valid, heater_on, mode, temperature, power, output ready);
endinterface

interface htc_cfg_if import htc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/htc_pid.sv
// PID step: error, windowed clamped integral, derivative and clamped power percent.
module htc_pid import htc_pkg::*; (
  input  logic [TEMP_W-1:0]      current,
  input  logic [TEMP_W-1:0]      target,
  input  logic signed [ERR_W-1:0] prev_err,
  input  logic [INTEG_W-1:0]     integ,
  input  gains_t                 gains,
  output pid_out_t               res
);

  localparam int P_W   = ERR_W + GAIN_W + 1;
  localparam int D_W   = ERR_W + GAIN_W + 2;
  localparam int I_W   = 20;
  localparam int SUM_W = D_W + 1;
  localparam int Q_W   = SUM_W - 8;

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W:0]    diff;
  logic signed [GAIN_W:0]   gp_s;
  logic signed [GAIN_W:0]   gi_s;
  logic signed [GAIN_W:0]   gd_s;
  logic signed [P_W-1:0]    p_term;
  logic signed [D_W-1:0]    d_term;
  logic signed [I_W-1:0]    i_prod;
  logic signed [I_W-1:0]    acc_sum;
  logic                     in_window;
  logic [INTEG_W-1:0]       integ_next;
  logic signed [SUM_W-1:0]  sum;
  logic [Q_W-1:0]           q;
  logic [POWER_W-1:0]       pct;

  assign err  = $signed({1'b0, target}) - $signed({1'b0, current});
  assign diff = $signed({err[ERR_W-1], err}) - $signed({prev_err[ERR_W-1], prev_err});
  assign gp_s = $signed({1'b0, gains.p});
  assign gi_s = $signed({1'b0, gains.i});
  assign gd_s = $signed({1'b0, gains.d});

  assign p_term  = P_W'(err) * P_W'(gp_s);
  assign d_term  = D_W'(diff) * D_W'(gd_s);
  assign i_prod  = I_W'(err) * I_W'(gi_s);
  assign acc_sum = I_W'($signed({1'b0, integ})) + i_prod;

  assign in_window = (err > -ERR_WINDOW) && (err < ERR_WINDOW);

  always_comb begin
    if (!in_window || acc_sum[I_W-1]) begin
      integ_next = '0;
    end else if (acc_sum > $signed(I_W'(INTEG_MAX))) begin
      integ_next = INTEG_W'(INTEG_MAX);
    end else begin
      integ_next = acc_sum[INTEG_W-1:0];
    end
  end

  assign sum = SUM_W'(p_term) + SUM_W'($signed({1'b0, integ_next})) + SUM_W'(d_term);
  assign q   = sum[SUM_W-1:8];

  always_comb begin
    if (sum[SUM_W-1] || sum == '0) begin
      pct = '0;
    end else if (q > Q_W'(POWER_MAX)) begin
      pct = POWER_W'(POWER_MAX);
    end else begin
      pct = q[POWER_W-1:0];
    end
  end

  assign res = '{pct: pct, integ: integ_next, err: err};

endmodule

### design/heater_temperature_controller.sv
// Heater controller top level: input register, mode machine, PID and PWM, result.
//
// Channels: item (sink) takes a control tick, a wake event or an autotune
// start; result (source) returns one item per input item with heater level,
// mode, temperature and power percent after that item; cfg (sink) writes
// sleep_temp (index 0), sleep_timeout (index 1) and error_temp (index 2), and
// is always ready. Write registers only while the block is idle.
// The ADC sample is converted to degrees as the item enters the input
// register; from there the mode machine, PID and PWM update the state once
// the result slot is free, and the result port shows that state directly.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single state-update stage.
// Reset clears all state to its power-up values; nothing is swept.
// When the receiver stalls, the result holds, the input register keeps one
// item, and item.ready drops until the result is transferred.
module heater_temperature_controller import htc_pkg::*; #(
  parameter int PWM_STEPS = 20
) (
  input  logic       clk,
  input  logic       rst,
  htc_item_if.sink   item,
  htc_result_if.source result,
  htc_cfg_if.sink    cfg
);

  localparam int PHASE_W = $clog2(PWM_STEPS);
  localparam int THR_W   = $clog2(POWER_MAX * PWM_STEPS + 1);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PWM_STEPS - 1);

  // input register
  logic              s_valid;
  logic [KIND_W-1:0] s_kind;
  logic [TEMP_W-1:0] s_temp;
  logic              s_master;
  logic [TEMP_W-1:0] s_target;

  // configuration
  logic [TEMP_W-1:0]    sleep_temp;
  logic [TIMEOUT_W-1:0] sleep_timeout;
  logic [TEMP_W-1:0]    error_temp;

  // state
  logic                    out_valid;
  logic [MODE_W-1:0]       mode_reg, mode_next;
  logic [TEMP_W-1:0]       temp_reg, temp_next;
  logic [TICK_W-1:0]       tick_count, tick_next;
  logic [TICK_W-1:0]       last_wake, last_wake_next;
  logic [TEMP_W-1:0]       tune_goal, tune_goal_next;
  logic [TUNE_CNT_W-1:0]   tune_cnt, tune_cnt_next;
  logic                    tune_heat, tune_heat_next;
  logic [PHASE_W-1:0]      pwm_phase, pwm_phase_next;
  logic signed [ERR_W-1:0] prev_err, prev_err_next;
  logic [INTEG_W-1:0]      integ, integ_next;
  gains_t                  gains, gains_next;
  logic                    heater_level, heater_level_next;
  logic [POWER_W-1:0]      power_reg, power_next;

  logic              advance;
  logic              take;
  logic [TICK_W-1:0] tick_inc;
  logic              over_temp;
  logic [MODE_W-1:0] mode_run;
  logic [TICK_W-1:0] wake_run;
  logic [TEMP_W-1:0] pid_target;
  pid_out_t          pid;
  logic [THR_W-1:0]  phase_lim;

  assign advance     = s_valid && (!out_valid || result.ready);
  assign item.ready  = !s_valid || advance;
  assign take        = item.valid && item.ready;
  assign cfg.ready   = 1'b1;

  assign result.valid       = out_valid;
  assign result.heater_on   = heater_level;
  assign result.mode        = mode_reg;
  assign result.temperature = temp_reg;
  assign result.power       = power_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (item.ready) begin
      s_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_kind   <= item.kind;
      s_temp   <= adc_to_degrees(item.adc_sample);
      s_master <= item.master_on;
      s_target <= item.setpoint;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_temp    <= SLEEP_TEMP_RESET;
      sleep_timeout <= SLEEP_TIMEOUT_RESET;
      error_temp    <= ERROR_TEMP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SLEEP_TEMP:    sleep_temp    <= cfg.data[TEMP_W-1:0];
        CFG_SLEEP_TIMEOUT: sleep_timeout <= cfg.data[TIMEOUT_W-1:0];
        CFG_ERROR_TEMP:    error_temp    <= cfg.data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick_inc   = tick_count + 1'b1;
  assign over_temp  = s_temp >= error_temp;
  assign mode_run   = over_temp ? MODE_ERROR :
                      (mode_reg == MODE_OFF) ? MODE_HEAT : mode_reg;
  assign wake_run   = (!over_temp && mode_reg == MODE_OFF) ? tick_inc : last_wake;
  assign pid_target = (mode_run == MODE_SLEEP) ? sleep_temp : s_target;
  assign phase_lim  = (THR_W'(pwm_phase) + 1'b1) * THR_W'(POWER_MAX);

  htc_pid u_pid (
    .current  (s_temp),
    .target   (pid_target),
    .prev_err (prev_err),
    .integ    (integ),
    .gains    (gains),
    .res      (pid)
  );

  always_comb begin
    logic                  drive;
    logic [POWER_W-1:0]    pct;
    logic [TUNE_CNT_W-1:0] cnt;
    mode_next         = mode_reg;
    temp_next         = temp_reg;
    tick_next         = tick_count;
    last_wake_next    = last_wake;
    tune_goal_next    = tune_goal;
    tune_cnt_next     = tune_cnt;
    tune_heat_next    = tune_heat;
    pwm_phase_next    = pwm_phase;
    prev_err_next     = prev_err;
    integ_next        = integ;
    gains_next        = gains;
    heater_level_next = heater_level;
    power_next        = power_reg;
    drive             = 1'b0;
    pct               = '0;
    cnt               = tune_cnt;
    if (advance) begin
      unique case (s_kind)
        KIND_TICK: begin
          tick_next         = tick_inc;
          heater_level_next = 1'b0;
          temp_next         = s_temp;
          if (!s_master) begin
            mode_next = MODE_OFF;
          end else begin
            mode_next      = mode_run;
            last_wake_next = wake_run;
            unique case (mode_run)
              MODE_HEAT: begin
                drive         = 1'b1;
                pct           = pid.pct;
                integ_next    = pid.integ;
                prev_err_next = pid.err;
                if (TICK_W'(tick_inc - wake_run) > TICK_W'(sleep_timeout)) begin
                  mode_next = MODE_SLEEP;
                end
              end
              MODE_SLEEP: begin
                drive         = 1'b1;
                pct           = pid.pct;
                integ_next    = pid.integ;
                prev_err_next = pid.err;
              end
              MODE_TUNE: begin
                drive = 1'b1;
                if (tune_heat) begin
                  pct = TUNE_POWER;
                  if (s_temp > tune_goal) begin
                    tune_heat_next = 1'b0;
                  end
                end else begin
                  pct = '0;
                  if (s_temp < tune_goal) begin
                    tune_heat_next = 1'b1;
                    if (tune_cnt < TUNE_CNT_MAX) begin
                      cnt = tune_cnt + 1'b1;
                    end
                  end
                end
                tune_cnt_next = cnt;
                if (cnt >= TUNE_ROUNDS) begin
                  gains_next = GAINS_TUNED;
                  mode_next  = MODE_HEAT;
                end
              end
              default: ;
            endcase
          end
        end
        KIND_WAKE: begin
          last_wake_next = tick_count;
          if (mode_reg == MODE_SLEEP) begin
            mode_next = MODE_HEAT;
          end
        end
        KIND_TUNE: begin
          if (mode_reg == MODE_HEAT || mode_reg == MODE_SLEEP) begin
            tune_goal_next = s_target;
            tune_cnt_next  = '0;
            mode_next      = MODE_TUNE;
          end
        end
        default: ;
      endcase
    end
    if (drive) begin
      power_next        = pct;
      heater_level_next = (pct != '0) &&
                          ((THR_W'(pct) * THR_W'(PWM_STEPS)) >= phase_lim);
      pwm_phase_next    = (pwm_phase == PHASE_LAST) ? '0 : pwm_phase + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      mode_reg     <= MODE_OFF;
      temp_reg     <= TEMP_RESET;
      tick_count   <= '0;
      last_wake    <= '0;
      tune_goal    <= '0;
      tune_cnt     <= '0;
      tune_heat    <= 1'b1;
      pwm_phase    <= '0;
      prev_err     <= '0;
      integ        <= '0;
      gains        <= GAINS_RESET;
      heater_level <= 1'b0;
      power_reg    <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      mode_reg     <= mode_next;
      temp_reg     <= temp_next;
      tick_count   <= tick_next;
      last_wake    <= last_wake_next;
      tune_goal    <= tune_goal_next;
      tune_cnt     <= tune_cnt_next;
      tune_heat    <= tune_heat_next;
      pwm_phase    <= pwm_phase_next;
      prev_err     <= prev_err_next;
      integ        <= integ_next;
      gains        <= gains_next;
      heater_level <= heater_level_next;
      power_reg    <= power_next;
    end
  end

endmodule
